FILE: rtl/wavh_pkg.sv
`timescale 1ns / 1ps

package wavh_pkg;

    // One parse result: event kind, completed field and error code.
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        logic [2:0]  code;
    } wavh_result_t;

    // A result with its strobe, as handed from the parser to the output queue.
    typedef struct packed {
        logic         valid;
        wavh_result_t res;
    } wavh_event_t;

endpackage

FILE: rtl/wavh_parse.sv
`timescale 1ns / 1ps

module wavh_parse
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         data_byte,
    input  logic               start_of_file,
    output wavh_pkg::wavh_event_t ev
);
    import wavh_pkg::*;

    typedef enum logic [4:0] {
        P_ID,
        P_RIFF_SIZE,
        P_WAVE_ID,
        P_FMT_SIZE,
        P_FMT_TAG,
        P_CHANNELS,
        P_RATE,
        P_BYTE_RATE,
        P_ALIGN,
        P_BITS,
        P_EXT_SIZE,
        P_VALID_BITS,
        P_MASK,
        P_GUID,
        P_FACT_SIZE,
        P_FACT_CNT,
        P_FACT_SKIP
    } phase_t;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_FACT = 32'h6661_6374;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [31:0] TAG_LIST = 32'h4C49_5354;

    localparam logic [3:0] EV_RIFF       = 4'd0;
    localparam logic [3:0] EV_FMT        = 4'd1;
    localparam logic [3:0] EV_FACT       = 4'd2;
    localparam logic [3:0] EV_FILE_SIZE  = 4'd3;
    localparam logic [3:0] EV_FORMAT     = 4'd4;
    localparam logic [3:0] EV_CHANNELS   = 4'd5;
    localparam logic [3:0] EV_RATE       = 4'd6;
    localparam logic [3:0] EV_BYTE_RATE  = 4'd7;
    localparam logic [3:0] EV_ALIGN      = 4'd8;
    localparam logic [3:0] EV_BITS       = 4'd9;
    localparam logic [3:0] EV_EXT_SIZE   = 4'd10;
    localparam logic [3:0] EV_VALID_BITS = 4'd11;
    localparam logic [3:0] EV_MASK       = 4'd12;
    localparam logic [3:0] EV_FACT_COUNT = 4'd13;
    localparam logic [3:0] EV_ERROR      = 4'd14;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
    localparam logic [2:0] ERR_NOT_WAVE  = 3'd2;
    localparam logic [2:0] ERR_FMT_SIZE  = 3'd3;
    localparam logic [2:0] ERR_FACT_SIZE = 3'd4;
    localparam logic [2:0] ERR_LIST      = 3'd5;
    localparam logic [2:0] ERR_DATA      = 3'd6;

    localparam logic [4:0] GUID_LAST = 5'd15;
    localparam logic signed [32:0] GUID_LEN = 33'sd16;

    function automatic logic [4:0] field_len(input phase_t p);
        case (p)
            P_RATE, P_BYTE_RATE, P_MASK: field_len = 5'd4;
            default:                     field_len = 5'd2;
        endcase
    endfunction

    function automatic logic [3:0] field_kind(input phase_t p);
        case (p)
            P_FMT_TAG:    field_kind = EV_FORMAT;
            P_CHANNELS:   field_kind = EV_CHANNELS;
            P_RATE:       field_kind = EV_RATE;
            P_BYTE_RATE:  field_kind = EV_BYTE_RATE;
            P_ALIGN:      field_kind = EV_ALIGN;
            P_BITS:       field_kind = EV_BITS;
            P_EXT_SIZE:   field_kind = EV_EXT_SIZE;
            P_VALID_BITS: field_kind = EV_VALID_BITS;
            default:      field_kind = EV_MASK;
        endcase
    endfunction

    function automatic logic [31:0] map_format(input logic [31:0] c);
        if (c == 32'd1 || c == 32'd3 || c == 32'd6 || c == 32'd7 || c == 32'h0000_FFFE)
            map_format = c;
        else
            map_format = 32'd0;
    endfunction

    phase_t                phase_reg, phase_next, phase_cur;
    logic [4:0]            idx_reg, idx_next, idx_cur;
    logic [31:0]           ids_reg, ids_next, ids_cur;
    logic [31:0]           acc_reg, acc_next, acc_cur;
    logic signed [32:0]    fmtl_reg, fmtl_next, fmtl_cur;
    logic [31:0]           factl_reg, factl_next, factl_cur;
    logic                  halted_reg, halted_next, halted_cur;

    logic [31:0]           ids_shift;
    logic [31:0]           acc_or;
    logic [4:0]            idx_inc;
    logic [1:0]            wave_sel;
    logic [7:0]            wave_byte;
    logic signed [32:0]    fmtl_sub;
    logic [31:0]           factl_dec;

    always_comb
    begin
        // start of file wipes the state before this byte is looked at
        phase_cur  = start_of_file ? P_ID  : phase_reg;
        idx_cur    = start_of_file ? 5'd0  : idx_reg;
        ids_cur    = start_of_file ? 32'd0 : ids_reg;
        acc_cur    = start_of_file ? 32'd0 : acc_reg;
        fmtl_cur   = start_of_file ? 33'sd0 : fmtl_reg;
        factl_cur  = start_of_file ? 32'd0 : factl_reg;
        halted_cur = start_of_file ? 1'b0  : halted_reg;

        ids_shift = {ids_cur[23:0], data_byte};
        acc_or    = acc_cur | ({24'd0, data_byte} << {idx_cur[1:0], 3'b000});
        idx_inc   = idx_cur + 5'd1;
        wave_sel  = 2'd3 - idx_cur[1:0];
        wave_byte = TAG_WAVE[{wave_sel, 3'b000} +: 8];
        fmtl_sub  = fmtl_cur - $signed({28'd0, field_len(phase_cur)});
        factl_dec = (factl_cur != 32'd0) ? factl_cur - 32'd1 : factl_cur;

        phase_next  = phase_cur;
        idx_next    = idx_cur;
        ids_next    = ids_cur;
        acc_next    = acc_cur;
        fmtl_next   = fmtl_cur;
        factl_next  = factl_cur;
        halted_next = halted_cur;

        ev.valid     = 1'b0;
        ev.res.kind  = EV_ERROR;
        ev.res.value = 32'd0;
        ev.res.code  = ERR_NONE;

        if (!halted_cur)
        begin
            case (phase_cur)
                P_ID:
                begin
                    ids_next = ids_shift;
                    idx_next = idx_inc;
                    if (idx_cur[1:0] == 2'd3)
                    begin
                        idx_next = 5'd0;
                        ev.valid = 1'b1;
                        if (ids_shift == TAG_RIFF)
                        begin
                            phase_next  = P_RIFF_SIZE;
                            ev.res.kind = EV_RIFF;
                        end
                        else if (ids_shift == TAG_FMT)
                        begin
                            phase_next  = P_FMT_SIZE;
                            ev.res.kind = EV_FMT;
                        end
                        else if (ids_shift == TAG_FACT)
                        begin
                            phase_next  = P_FACT_SIZE;
                            ev.res.kind = EV_FACT;
                        end
                        else
                        begin
                            halted_next = 1'b1;
                            if (ids_shift == TAG_DATA)
                                ev.res.code = ERR_DATA;
                            else if (ids_shift == TAG_LIST)
                                ev.res.code = ERR_LIST;
                            else
                                ev.res.code = ERR_UNKNOWN;
                        end
                    end
                end
                P_RIFF_SIZE, P_FMT_SIZE, P_FACT_SIZE, P_FACT_CNT:
                begin
                    acc_next = acc_or;
                    idx_next = idx_inc;
                    if (idx_cur[1:0] == 2'd3)
                    begin
                        acc_next = 32'd0;
                        idx_next = 5'd0;
                        case (phase_cur)
                            P_RIFF_SIZE:
                            begin
                                phase_next   = P_WAVE_ID;
                                ev.valid     = 1'b1;
                                ev.res.kind  = EV_FILE_SIZE;
                                ev.res.value = acc_or + 32'd8;
                            end
                            P_FMT_SIZE:
                            begin
                                fmtl_next  = $signed({1'b0, acc_or});
                                phase_next = P_FMT_TAG;
                            end
                            P_FACT_SIZE:
                            begin
                                if (acc_or < 32'd4)
                                begin
                                    halted_next = 1'b1;
                                    ev.valid    = 1'b1;
                                    ev.res.code = ERR_FACT_SIZE;
                                end
                                else
                                begin
                                    factl_next = acc_or - 32'd4;
                                    phase_next = P_FACT_CNT;
                                end
                            end
                            default:
                            begin
                                phase_next   = (factl_cur == 32'd0) ? P_ID : P_FACT_SKIP;
                                ev.valid     = 1'b1;
                                ev.res.kind  = EV_FACT_COUNT;
                                ev.res.value = acc_or;
                            end
                        endcase
                    end
                end
                P_WAVE_ID:
                begin
                    if (data_byte != wave_byte)
                    begin
                        halted_next = 1'b1;
                        ev.valid    = 1'b1;
                        ev.res.code = ERR_NOT_WAVE;
                    end
                    else if (idx_cur[1:0] == 2'd3)
                    begin
                        idx_next   = 5'd0;
                        phase_next = P_ID;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
                P_FMT_TAG, P_CHANNELS, P_RATE, P_BYTE_RATE, P_ALIGN,
                P_BITS, P_EXT_SIZE, P_VALID_BITS, P_MASK:
                begin
                    acc_next = acc_or;
                    idx_next = idx_inc;
                    if (idx_inc >= field_len(phase_cur))
                    begin
                        acc_next     = 32'd0;
                        idx_next     = 5'd0;
                        fmtl_next    = fmtl_sub;
                        ev.valid     = 1'b1;
                        ev.res.kind  = field_kind(phase_cur);
                        ev.res.value = (phase_cur == P_FMT_TAG) ? map_format(acc_or) : acc_or;
                        if (phase_cur < P_BITS)
                            phase_next = phase_t'(phase_cur + 5'd1);
                        else if (fmtl_sub == 33'sd0)
                            phase_next = P_ID;
                        else if (fmtl_sub[32])
                        begin
                            // short fmt chunk: error replaces the field event
                            halted_next  = 1'b1;
                            ev.res.kind  = EV_ERROR;
                            ev.res.value = 32'd0;
                            ev.res.code  = ERR_FMT_SIZE;
                        end
                        else
                            phase_next = phase_t'(phase_cur + 5'd1);
                    end
                end
                P_GUID:
                begin
                    idx_next = idx_inc;
                    if (idx_cur == GUID_LAST)
                    begin
                        idx_next  = 5'd0;
                        fmtl_next = fmtl_cur - GUID_LEN;
                        if (fmtl_cur != GUID_LEN)
                        begin
                            halted_next = 1'b1;
                            ev.valid    = 1'b1;
                            ev.res.code = ERR_FMT_SIZE;
                        end
                        else
                            phase_next = P_ID;
                    end
                end
                P_FACT_SKIP:
                begin
                    factl_next = factl_dec;
                    if (factl_dec == 32'd0)
                        phase_next = P_ID;
                end
                default:
                begin
                    phase_next = P_ID;
                    idx_next   = 5'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= P_ID;
            idx_reg    <= 5'd0;
            ids_reg    <= 32'd0;
            acc_reg    <= 32'd0;
            fmtl_reg   <= 33'sd0;
            factl_reg  <= 32'd0;
            halted_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            ids_reg    <= ids_next;
            acc_reg    <= acc_next;
            fmtl_reg   <= fmtl_next;
            factl_reg  <= factl_next;
            halted_reg <= halted_next;
        end
    end

endmodule

FILE: rtl/wavh_out_fifo.sv
`timescale 1ns / 1ps

module wavh_out_fifo
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  wavh_pkg::wavh_result_t push_res,
    input  logic                   pop,
    output logic                   full,
    output logic                   not_empty,
    output wavh_pkg::wavh_result_t head
);
    import wavh_pkg::*;

    wavh_result_t slot_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

FILE: rtl/wav_header_chunk_parser.sv
`timescale 1ns / 1ps
// A taken byte is held in the input register, then parsed and its result queued.
// Throughput: one byte per cycle while the result queue has room, set by the parse step
// between the input register and the two-entry result queue; the queue lets the slave
// side keep running while one result waits on the master side.
// Reset: rst_n clears the parse state, input register and result queue asynchronously.

module wav_header_chunk_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] start_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] field_value, [34:32] error_code, [39:35] zero
    output logic [3:0]  m_tuser    // [3:0] event_kind
);
    import wavh_pkg::*;

    // input register: holds one byte request until the parser takes it
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_sof_reg;

    logic         q_full;
    logic         q_not_empty;
    logic         step_go;
    wavh_event_t  ev;
    wavh_result_t head;

    // advance the parser whenever a byte is held and the queue has room
    assign step_go  = in_valid_reg && !q_full;
    assign s_tready = !in_valid_reg || step_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_sof_reg  <= s_tuser[0];
        end
    end

    wavh_parse u_parse
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step_go),
        .data_byte     (in_byte_reg),
        .start_of_file (in_sof_reg),
        .ev            (ev)
    );

    // drop bytes that cause no result; queue the rest
    wavh_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step_go && ev.valid),
        .push_res  (ev.res),
        .pop       (m_tvalid && m_tready),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    assign m_tvalid = q_not_empty;
    assign m_tdata  = {5'd0, head.code, head.value};
    assign m_tuser  = head.kind;

endmodule
